FILE: sv/feedback_comb_echo_unit_assert.svh
// Assertion macros for the feedback comb echo unit.
// Included by the top level; depends on nothing else.
`ifndef FEEDBACK_COMB_ECHO_UNIT_ASSERT_SVH
`define FEEDBACK_COMB_ECHO_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fce_pkg.sv
// Package for the feedback comb echo unit: fixed widths and mixing constants.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package fce_pkg;

  localparam int DELAY_BITS = 16;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd24000;

  // The dry coefficient 0.5 in Q0.15 is a shift by 14.
  localparam int COEF_DRY_SHIFT = 14;
  // The wet coefficient 0.4 in Q0.15.
  localparam logic [14:0] COEF_WET = 15'd13107;
  localparam int FRAC_BITS = 15;
  localparam logic [15:0] ROUND_BIAS = 16'd16384;

endpackage

FILE: sv/fce_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same entry in one cycle return the old data.
`timescale 1ns / 1ps

module fce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/feedback_comb_echo_unit.sv
// Feedback comb echo: delay line in a RAM, one mixing stage and an output register.
// Depends on fce_pkg, fce_ram and feedback_comb_echo_unit_assert.svh.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one sample and a silent flag per
//   item; output channel out_valid_o/out_ready_i returns one sample and the
//   echo_active flag per item, in order. cfg_we_i/cfg_wdata_i set the echo delay
//   in samples (zero acts as one); the user must write them only while the unit is
//   idle, which is not enforced. Throughput is one item per cycle unless the
//   output stalls: the delay line RAM is read when an item is accepted and written
//   as it leaves the mixing stage, and a same-cycle read of the entry being written
//   is served from a forwarding register, so even a delay of one runs at full rate.
//   The recursion output -> multiply -> add -> saturate fits in the one stage.
//   A silent item returns zero and leaves the pointer, fill count and RAM alone.
//   Reset clears the write pointer and fill count and loads a delay of 24000.
//   The RAM needs no clearing pass, since an entry is read only after it was
//   written. When the receiver stalls, the result waits in the output register,
//   one more item waits in the mixing stage, and in_ready_o drops only then.
`timescale 1ns / 1ps

module feedback_comb_echo_unit #(
  parameter int DELAY_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fce_pkg::DELAY_BITS-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_BITS-1:0]          in_sample_i,
  input  logic                            silent_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [SAMPLE_BITS-1:0]          out_sample_o,
  output logic                            echo_active_o
);

  import fce_pkg::*;

  `include "feedback_comb_echo_unit_assert.svh"

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int CW = $clog2(DELAY_DEPTH + 1);
  localparam int WW = (CW > DELAY_BITS) ? CW + 1 : DELAY_BITS + 1;
  localparam int SUMW = SAMPLE_BITS + 16;
  localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(DELAY_DEPTH);
  localparam logic [WW-1:0] DEPTH_W = WW'(DELAY_DEPTH);
  localparam logic signed [SUMW-1:0] SMAX_W =
    $signed({{(SUMW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SUMW-1:0] SMIN_W = ~SMAX_W;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [AW-1:0]          wp;
    logic                   echo;
    logic                   silent;
    logic                   fwd;
  } s1_t;

  logic [DELAY_BITS-1:0]  delay_q;
  logic [AW-1:0]          wp_q;
  logic [CW-1:0]          fill_q;
  logic                   s1_valid_q;
  s1_t                    s1_q;
  logic [SAMPLE_BITS-1:0] fwd_data_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic                   echo_q;

  logic                   in_accept;
  logic                   s1_adv;
  logic [DELAY_BITS-1:0]  delay_eff;
  logic [WW-1:0]          d_w;
  logic [WW-1:0]          wp_w;
  logic [WW-1:0]          fill_w;
  logic [WW-1:0]          rd_w;
  logic [AW-1:0]          rd_addr;
  logic                   echo_now;
  logic                   fwd_now;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] wet_in;
  logic signed [SUMW-1:0] dry_term;
  logic signed [SUMW-1:0] wet_term;
  logic signed [SUMW-1:0] sum_mix;
  logic signed [SUMW-1:0] q_mix;
  logic [SAMPLE_BITS-1:0] y_mix;
  logic [SAMPLE_BITS-1:0] y_s1;
  logic                   ram_we;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    delay_eff = (delay_q == '0) ? DELAY_BITS'(1) : delay_q;
    d_w       = WW'(delay_eff);
    wp_w      = WW'(wp_q);
    fill_w    = WW'(fill_q);
    echo_now  = (d_w < DEPTH_W) && (fill_w > d_w) && !silent_i;
    rd_w      = (wp_w >= d_w) ? (wp_w - d_w) : (wp_w + DEPTH_W - d_w);
    rd_addr   = rd_w[AW-1:0];
    fwd_now   = s1_adv && !s1_q.silent && (rd_addr == s1_q.wp);
  end

  always_comb begin
    wet_in   = s1_q.fwd ? fwd_data_q : ram_rdata;
    dry_term = SUMW'($signed(s1_q.x)) <<< COEF_DRY_SHIFT;
    wet_term = SUMW'($signed(wet_in)) * $signed(SUMW'(COEF_WET));
    sum_mix  = dry_term + wet_term + $signed(SUMW'(ROUND_BIAS));
    q_mix    = sum_mix >>> FRAC_BITS;
    if (q_mix > SMAX_W) begin
      y_mix = SMAX_W[SAMPLE_BITS-1:0];
    end else if (q_mix < SMIN_W) begin
      y_mix = SMIN_W[SAMPLE_BITS-1:0];
    end else begin
      y_mix = q_mix[SAMPLE_BITS-1:0];
    end
    y_s1   = s1_q.echo ? y_mix : s1_q.x;
    ram_we = s1_adv && !s1_q.silent;
  end

  fce_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DELAY_DEPTH)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_q.wp),
    .wdata_i(y_s1),
    .re_i   (in_accept && echo_now),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= DELAY_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      if (in_accept && !silent_i) begin
        wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + CW'(1);
        end
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.x      <= in_sample_i;
      s1_q.wp     <= wp_q;
      s1_q.echo   <= echo_now;
      s1_q.silent <= silent_i;
      s1_q.fwd    <= fwd_now;
      fwd_data_q  <= y_s1;
    end
    if (s1_adv) begin
      out_sample_q <= s1_q.silent ? '0 : y_s1;
      echo_q       <= s1_q.echo && !s1_q.silent;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign echo_active_o = echo_q;

  `FCE_ASSERT_SAME(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FILL_FULL, "fill count past depth")
  `FCE_ASSERT_NEXT(a_stage_load, clk_i, rst_ni, in_accept, s1_valid_q, "accepted item not staged")
  `FCE_ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_q), "stalled stage changed")
  `FCE_ASSERT_NEXT(a_silent_keep, clk_i, rst_ni, in_accept && silent_i, $stable(wp_q) && $stable(fill_q), "silent item changed state")
  `FCE_ASSERT_NEXT(a_wp_step, clk_i, rst_ni, in_accept && !silent_i, wp_q != $past(wp_q), "write pointer did not advance")

endmodule
